// ===== sv/quad_batch_vertex_expander_macros.svh =====
// Assertion macros for the quad batch vertex expander checker.
// No dependencies; included by files that assert.
`ifndef QUAD_BATCH_VERTEX_EXPANDER_MACROS_SVH
`define QUAD_BATCH_VERTEX_EXPANDER_MACROS_SVH

// same-cycle implication
`define QBVE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QBVE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/qbve_pkg.sv =====
// Shared types, codes, beat layouts and the sequencer microcode ROM
// for the quad batch vertex expander. No dependencies.
package qbve_pkg;

   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int TEX_ID_W    = 32;
   localparam int TEX_SLOT_W  = 3;
   localparam int COORD_W     = 16;
   localparam int SIZE_W      = 15;
   localparam int UV_W        = 16;
   localparam int COLOR_W     = 24;
   localparam int MAXV_W      = 16;

   // request beat layout, lowest bit first
   localparam int REQ_POS_X   = 0;
   localparam int REQ_POS_Y   = REQ_POS_X + COORD_W;
   localparam int REQ_SIZE_X  = REQ_POS_Y + COORD_W;
   localparam int REQ_SIZE_Y  = REQ_SIZE_X + SIZE_W;
   localparam int REQ_U_MIN   = REQ_SIZE_Y + SIZE_W;
   localparam int REQ_V_MIN   = REQ_U_MIN + UV_W;
   localparam int REQ_U_MAX   = REQ_V_MIN + UV_W;
   localparam int REQ_V_MAX   = REQ_U_MAX + UV_W;
   localparam int REQ_COLOR   = REQ_V_MAX + UV_W;
   localparam int REQ_TEX_ID  = REQ_COLOR + COLOR_W;
   localparam int REQ_BITS    = REQ_TEX_ID + TEX_ID_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   // result beat layout, lowest bit first
   localparam int RSP_X       = 0;
   localparam int RSP_Y       = RSP_X + COORD_W;
   localparam int RSP_U       = RSP_Y + COORD_W;
   localparam int RSP_V       = RSP_U + UV_W;
   localparam int RSP_COLOR   = RSP_V + UV_W;
   localparam int RSP_SLOT    = RSP_COLOR + COLOR_W;
   localparam int RSP_BITS    = RSP_SLOT + TEX_SLOT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_TEXTURED = 2'd0,
      OP_COLOR    = 2'd1,
      OP_CLEAR    = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_VTX_OVF    = 2'd1,
      STATUS_SLOTS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      STEP_IDLE = 3'd0,
      STEP_V0   = 3'd1,
      STEP_V1   = 3'd2,
      STEP_V2   = 3'd3,
      STEP_V3   = 3'd4,
      STEP_V4   = 3'd5,
      STEP_V5   = 3'd6,
      STEP_ERR  = 3'd7
   } step_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_HOME,
      SEQ_DISPATCH
   } seq_type;

   typedef struct packed {
      logic    take;
      logic    emit;
      logic    err;
      logic    x_hi;
      logic    y_hi;
      logic    last;
      seq_type seq;
   } ucode_type;

   typedef struct packed {
      logic clear;
      logic append;
   } tbl_cmd_type;

   typedef struct packed {
      logic hit;
      logic full;
   } tbl_rslt_type;

   // microcode ROM: corner order lo/lo, hi/lo, hi/hi, hi/hi, lo/hi, lo/lo
   function automatic ucode_type ucode(step_type step);
      ucode_type w;
      w = '{take: 1'b0, emit: 1'b1, err: 1'b0, x_hi: 1'b0, y_hi: 1'b0,
            last: 1'b0, seq: SEQ_NEXT};
      unique case (step)
         STEP_IDLE: begin
            w.take = 1'b1;
            w.emit = 1'b0;
            w.seq  = SEQ_DISPATCH;
         end
         STEP_V0: ;
         STEP_V1: w.x_hi = 1'b1;
         STEP_V2: begin
            w.x_hi = 1'b1;
            w.y_hi = 1'b1;
         end
         STEP_V3: begin
            w.x_hi = 1'b1;
            w.y_hi = 1'b1;
         end
         STEP_V4: w.y_hi = 1'b1;
         STEP_V5: begin
            w.last = 1'b1;
            w.seq  = SEQ_HOME;
         end
         STEP_ERR: begin
            w.err  = 1'b1;
            w.last = 1'b1;
            w.seq  = SEQ_HOME;
         end
         default: w.seq = SEQ_HOME;
      endcase
      return w;
   endfunction

endpackage

// ===== sv/qbve_slot_table.sv =====
// Texture slot table: parallel handle lookup, append and clear.
// Depends on qbve_pkg.
module qbve_slot_table #(
   parameter int TEXTURE_SLOTS = 8,
   parameter int SLOT_W        = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [qbve_pkg::TEX_ID_W-1:0]  lookup_id,
   input  qbve_pkg::tbl_cmd_type          cmd,
   output qbve_pkg::tbl_rslt_type         rslt,
   output logic [SLOT_W-1:0]              slot
);
   import qbve_pkg::*;

   localparam int CNT_W = $clog2(TEXTURE_SLOTS + 1);

   logic [TEX_ID_W-1:0] table_ff [TEXTURE_SLOTS];
   logic [CNT_W-1:0]    used_ff;
   logic [CNT_W-1:0]    used_in;
   logic                hit;
   logic [SLOT_W-1:0]   hit_slot;

   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = 0; i < TEXTURE_SLOTS; i++) begin
         if (!hit && (CNT_W'(i) < used_ff) && (table_ff[i] == lookup_id)) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
      end
   end

   assign rslt.hit  = hit;
   assign rslt.full = (used_ff == CNT_W'(TEXTURE_SLOTS));
   assign slot      = hit ? hit_slot : SLOT_W'(used_ff);

   always_comb begin
      used_in = used_ff;
      priority if (cmd.clear) begin
         used_in = '0;
      end else if (cmd.append) begin
         used_in = used_ff + CNT_W'(1);
      end else begin
         used_in = used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !cmd.clear) begin
         table_ff[SLOT_W'(used_ff)] <= lookup_id;
      end
   end

endmodule

// ===== sv/quad_batch_vertex_expander.sv =====
// Quad to six-vertex expander, top level: microcode sequencer, vertex datapath,
// output register. Depends on qbve_pkg and qbve_slot_table.
//
//   channel | dir | beat content
//   req_    | in  | quad fields in tdata, operation in tuser
//   rsp_    | out | vertex fields in tdata, last in tlast, status in tuser
//   csr_    | in  | max_vertices write
//
// A drawn quad has an accept step, then six vertex steps, one beat each through
// the single output register; a rejected quad, the accept and an error step; a
// clear, the accept step only. Reset clears step counter, slot count, vertex
// count and output valid, not slot table contents. A stalled beat holds the step.
module quad_batch_vertex_expander #(
   parameter int TEXTURE_SLOTS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x, pos_y, size_x, size_y, u_min, v_min, u_max, v_max, color_rgb, texture_id
   input  logic [qbve_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // operation
   input  logic [qbve_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // vert_x, vert_y, tex_u, tex_v, vert_color, tex_slot
   output logic [qbve_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   // status
   output logic [qbve_pkg::STATUS_W-1:0]     rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qbve_pkg::MAXV_W-1:0]       csr_wdata
);
   import qbve_pkg::*;

   localparam int SLOT_W = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;

   step_type            step_ff, step_in;
   ucode_type           word;
   logic                accept;
   logic                out_free;

   logic [MAXV_W-1:0]   max_vertices_ff;
   logic [MAXV_W-1:0]   vertex_count_ff, vertex_count_in;

   logic [COORD_W-1:0]  x0_ff, y0_ff, x1_ff, y1_ff;
   logic [UV_W-1:0]     u0_ff, v0_ff, u1_ff, v1_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [TEX_SLOT_W-1:0] slot_ff;
   status_type          status_ff;

   logic [COORD_W-1:0]  in_x, in_y;
   logic [SIZE_W-1:0]   in_sx, in_sy;
   logic [TEX_ID_W-1:0] in_tex;
   logic [COORD_W:0]    sum_x, sum_y;
   logic [COORD_W-1:0]  sat_x, sat_y;
   logic                textured;
   logic                vtx_ovf;
   step_type            dispatch;
   status_type          status_in;
   logic                drawn;
   tbl_cmd_type         tbl_cmd;
   tbl_rslt_type        tbl_rslt;
   logic [SLOT_W-1:0]   tbl_slot;
   logic [31:0]         slot_wide;

   logic                rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                rsp_tlast_ff, rsp_tlast_in;
   logic [STATUS_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   assign word       = ucode(step_ff);
   assign req_tready = word.take;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign in_x   = req_tdata[REQ_POS_X +: COORD_W];
   assign in_y   = req_tdata[REQ_POS_Y +: COORD_W];
   assign in_sx  = req_tdata[REQ_SIZE_X +: SIZE_W];
   assign in_sy  = req_tdata[REQ_SIZE_Y +: SIZE_W];
   assign in_tex = req_tdata[REQ_TEX_ID +: TEX_ID_W];

   // saturating corner sums; origin is never below -32768 so only the top clips
   assign sum_x = {in_x[COORD_W-1], in_x} + {2'b00, in_sx};
   assign sum_y = {in_y[COORD_W-1], in_y} + {2'b00, in_sy};
   assign sat_x = (!sum_x[COORD_W] && sum_x[COORD_W-1]) ? 16'h7FFF : sum_x[COORD_W-1:0];
   assign sat_y = (!sum_y[COORD_W] && sum_y[COORD_W-1]) ? 16'h7FFF : sum_y[COORD_W-1:0];

   assign vtx_ovf  = ({1'b0, vertex_count_ff} + 17'd6) > {1'b0, max_vertices_ff};
   assign textured = (req_tuser == OP_TEXTURED);

   always_comb begin
      dispatch  = STEP_IDLE;
      status_in = STATUS_OK;
      drawn     = 1'b0;
      tbl_cmd   = '0;
      unique case (req_tuser)
         OP_TEXTURED, OP_COLOR: begin
            priority if (vtx_ovf) begin
               dispatch  = STEP_ERR;
               status_in = STATUS_VTX_OVF;
            end else if (textured && !tbl_rslt.hit && tbl_rslt.full) begin
               dispatch  = STEP_ERR;
               status_in = STATUS_SLOTS_FULL;
            end else begin
               dispatch       = STEP_V0;
               drawn          = 1'b1;
               tbl_cmd.append = accept && textured && !tbl_rslt.hit;
            end
         end
         OP_CLEAR: tbl_cmd.clear = accept;
         default: ;
      endcase
   end

   qbve_slot_table #(
      .TEXTURE_SLOTS (TEXTURE_SLOTS),
      .SLOT_W        (SLOT_W)
   ) u_slot_table (
      .clock     (clock),
      .reset     (reset),
      .lookup_id (in_tex),
      .cmd       (tbl_cmd),
      .rslt      (tbl_rslt),
      .slot      (tbl_slot)
   );

   assign slot_wide = 32'(tbl_slot);

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (accept) begin
         priority if (tbl_cmd.clear) begin
            vertex_count_in = '0;
         end else if (drawn) begin
            vertex_count_in = vertex_count_ff + MAXV_W'(6);
         end else begin
            vertex_count_in = vertex_count_ff;
         end
      end
   end

   always_comb begin
      step_in = step_ff;
      unique case (word.seq)
         SEQ_DISPATCH: if (accept) step_in = dispatch;
         SEQ_NEXT:     if (out_free) step_in = step_type'(step_ff + 3'd1);
         SEQ_HOME:     if (out_free) step_in = STEP_IDLE;
         default:      step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= STEP_IDLE;
         vertex_count_ff <= '0;
         max_vertices_ff <= 16'hFFFF;
      end else begin
         step_ff         <= step_in;
         vertex_count_ff <= vertex_count_in;
         if (csr_valid && csr_ready) begin
            max_vertices_ff <= csr_wdata;
         end
      end
   end

   // quad latch
   always_ff @(posedge clock) begin
      if (accept) begin
         x0_ff     <= in_x;
         y0_ff     <= in_y;
         x1_ff     <= sat_x;
         y1_ff     <= sat_y;
         color_ff  <= req_tdata[REQ_COLOR +: COLOR_W];
         status_ff <= status_in;
         if (textured) begin
            u0_ff   <= req_tdata[REQ_U_MIN +: UV_W];
            v0_ff   <= req_tdata[REQ_V_MIN +: UV_W];
            u1_ff   <= req_tdata[REQ_U_MAX +: UV_W];
            v1_ff   <= req_tdata[REQ_V_MAX +: UV_W];
            slot_ff <= slot_wide[TEX_SLOT_W-1:0];
         end else begin
            u0_ff   <= '0;
            v0_ff   <= '0;
            u1_ff   <= '0;
            v1_ff   <= '0;
            slot_ff <= '0;
         end
      end
   end

   always_comb begin
      rsp_tdata_in = '0;
      rsp_tlast_in = word.last;
      rsp_tuser_in = STATUS_OK;
      if (word.err) begin
         rsp_tuser_in = status_ff;
      end else begin
         rsp_tdata_in[RSP_X +: COORD_W]      = word.x_hi ? x1_ff : x0_ff;
         rsp_tdata_in[RSP_Y +: COORD_W]      = word.y_hi ? y1_ff : y0_ff;
         rsp_tdata_in[RSP_U +: UV_W]         = word.x_hi ? u1_ff : u0_ff;
         rsp_tdata_in[RSP_V +: UV_W]         = word.y_hi ? v1_ff : v0_ff;
         rsp_tdata_in[RSP_COLOR +: COLOR_W]  = color_ff;
         rsp_tdata_in[RSP_SLOT +: TEX_SLOT_W] = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (word.emit && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (word.emit && out_free) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= rsp_tlast_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== sv/qbve_checker.sv =====
// Port-level checks for the quad batch vertex expander, bound to the top.
// Depends on qbve_pkg and quad_batch_vertex_expander_macros.svh.
`include "quad_batch_vertex_expander_macros.svh"

module qbve_port_checks (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [qbve_pkg::OP_W-1:0]         req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [qbve_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tlast,
   input logic [qbve_pkg::STATUS_W-1:0]     rsp_tuser
);
   import qbve_pkg::*;

   `QBVE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser),
      "stalled result beat changed")

   `QBVE_ASSERT_NOW(a_err_beat, rsp_tvalid && (rsp_tuser != STATUS_OK),
      rsp_tlast && (rsp_tdata == '0), "error beat not last or not zero")

   `QBVE_ASSERT_NEXT(a_quad_busy,
      req_tvalid && req_tready && ((req_tuser == OP_TEXTURED) || (req_tuser == OP_COLOR)),
      !req_tready, "request taken while a quad is in flight")

   `QBVE_ASSERT_NOW(a_mid_quad, rsp_tvalid && !rsp_tlast,
      !req_tready, "request taken between vertex beats")

endmodule

bind quad_batch_vertex_expander qbve_port_checks u_qbve_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
